// ===== hw/rtl/led_matrix_row_scan_driver_defines.svh =====
// Assertion macros used by the LED matrix scan driver checker.
`ifndef LED_MATRIX_ROW_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_ROW_SCAN_DRIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LMRSD_ASSERT_IMPLY(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("scan driver check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define LMRSD_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("scan driver check failed: next-cycle implication");

`endif

// ===== hw/rtl/lmrsd_pkg.sv =====
// Package: constants, codes and tables of the LED matrix scan driver.
package lmrsd_pkg;

    // Default geometry
    localparam int DEF_COLUMNS = 90;
    localparam int DEF_ROWS    = 7;
    localparam int DEF_PLANES  = 8;

    localparam int PIXEL_W   = 8;
    localparam int ON_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int ROWIDX_W  = 3;

    // Register reset values
    localparam logic [ON_W-1:0]    RST_BINARY_ON_TICKS  = 16'd400;
    localparam logic [PIXEL_W-1:0] RST_BINARY_THRESHOLD = 8'd0;

    // Per-plane on-time in ticks for the PWM scan
    localparam int ONTAB_W = 9;
    localparam logic [ONTAB_W-1:0] PLANE_ON_TICKS [8] = '{
        9'd1, 9'd30, 9'd60, 9'd90, 9'd120, 9'd160, 9'd250, 9'd400
    };

    // Request commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SWAP  = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_MODE        = 2'd0,
        REG_BINARY_ON_TICKS  = 2'd1,
        REG_BINARY_THRESHOLD = 2'd2
    } reg_idx_t;

    // Row scan phases
    typedef enum logic [1:0] {
        PH_EVEN  = 2'd0,
        PH_ODD   = 2'd1,
        PH_LATCH = 2'd2,
        PH_ON    = 2'd3
    } phase_t;

endpackage

// ===== hw/rtl/led_matrix_row_scan_driver.sv =====
// Top level: double-buffered LED matrix row scanner with binary and PWM scan.
//
// Takes one request per clock while in_stall is low and returns one result per request
// through the step register and then the output registers; the frame RAMs' registered
// read port, which the shift data comes from, is read alongside the step register. Write
// requests store a pixel into the draw buffer, swap requests exchange draw and display
// buffers, tick requests step the scan sequencer one pin step. After reset both frame
// buffers are cleared, one entry per cycle over all ROWS*COLUMNS entries (630 at the
// defaults); in_stall is high for the whole pass; config writes are taken as usual.
module led_matrix_row_scan_driver #(
    parameter int COLUMNS = lmrsd_pkg::DEF_COLUMNS,
    parameter int ROWS    = lmrsd_pkg::DEF_ROWS,
    parameter int PLANES  = lmrsd_pkg::DEF_PLANES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [lmrsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmrsd_pkg::CFG_DAT_W-1:0]    cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         command,
    input  logic [6:0]                         column,
    input  logic [2:0]                         row_number,
    input  logic [lmrsd_pkg::PIXEL_W-1:0]      pixel_value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               shift_data,
    output logic                               clock_even,
    output logic                               clock_odd,
    output logic                               latch,
    output logic                               enable_n,
    output logic                               row_drive,
    output logic [lmrsd_pkg::ROWIDX_W-1:0]     row_index,
    output logic                               frame_done
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PL_W   = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int PIX_W  = lmrsd_pkg::PIXEL_W;
    localparam int ON_W   = lmrsd_pkg::ON_W;
    localparam int RI_W   = lmrsd_pkg::ROWIDX_W;

    // Threshold of each PWM plane
    localparam logic [PIX_W-1:0] PLANE_THR [8] = '{
        PIX_W'(0 * 256 / PLANES), PIX_W'(1 * 256 / PLANES),
        PIX_W'(2 * 256 / PLANES), PIX_W'(3 * 256 / PLANES),
        PIX_W'(4 * 256 / PLANES), PIX_W'(5 * 256 / PLANES),
        PIX_W'(6 * 256 / PLANES), PIX_W'(7 * 256 / PLANES)
    };

    // Pin levels of one step, before the shift data is known
    typedef struct packed {
        logic             shifting;
        logic             ce;
        logic             co;
        logic             la;
        logic             en;
        logic             rd;
        logic [RI_W-1:0]  ridx;
        logic             fd;
        logic [PIX_W-1:0] thr;
        logic             sel;
    } step_t;

    // Configuration registers
    logic             scan_mode_reg;
    logic [ON_W-1:0]  binary_on_ticks_reg;
    logic [PIX_W-1:0] binary_threshold_reg;

    // Sequencer state
    logic                display_select_reg, display_select_next;
    logic [ROW_W-1:0]    scan_row_reg, scan_row_next;
    logic [PL_W-1:0]     plane_index_reg, plane_index_next;
    logic [POS_W-1:0]    shift_position_reg, shift_position_next;
    lmrsd_pkg::phase_t   scan_phase_reg, scan_phase_next;
    logic [ON_W-1:0]     on_counter_reg, on_counter_next;

    // Clearing pass
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // Pipeline
    logic  s1_valid_reg, s1_valid_next;
    step_t s1_reg;
    step_t step_comb;
    logic  out_valid_reg, out_valid_next;

    logic shift_data_reg, clock_even_reg, clock_odd_reg, latch_reg;
    logic enable_n_reg, row_drive_reg, frame_done_reg;
    logic [RI_W-1:0] row_index_reg;

    // Handshake and decode
    logic              advance;
    logic              accept;
    logic              is_tick;
    logic              pix_write;
    logic              write_in_range;
    logic [POS_W:0]    pos_sum;
    logic [ON_W:0]     cnt_sum;
    logic [ON_W:0]     cur_on_ticks;
    logic              on_end;
    logic              row_last;
    logic              plane_last;
    logic [2:0]        plane3;
    logic [ROW_W+2:0]  row_ext;
    logic [PL_W+2:0]   plane_ext;

    // Frame RAM ports
    logic              wr_en_a, wr_en_b;
    logic [ADDR_W-1:0] wr_addr, rd_addr, pix_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [PIX_W-1:0]  rd_data_a, rd_data_b, shown_pix;

    // Request handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing_reg || (s1_valid_reg && !advance);
    assign accept   = in_valid && !in_stall;
    assign is_tick  = accept && (lmrsd_pkg::cmd_t'(command) == lmrsd_pkg::CMD_TICK);

    // Live scan parameters
    assign plane_ext = {3'b000, plane_index_reg};
    assign plane3    = plane_ext[2:0];
    assign row_ext   = {3'b000, scan_row_reg};
    assign cur_on_ticks = scan_mode_reg ?
        (ON_W + 1)'(lmrsd_pkg::PLANE_ON_TICKS[plane3]) :
        ((binary_on_ticks_reg == '0) ? (ON_W + 1)'(1) : {1'b0, binary_on_ticks_reg});

    assign pos_sum    = {1'b0, shift_position_reg} + (POS_W + 1)'(2);
    assign cnt_sum    = {1'b0, on_counter_reg} + (ON_W + 1)'(1);
    assign on_end     = cnt_sum >= cur_on_ticks;
    assign row_last   = scan_row_reg == ROW_W'(ROWS - 1);
    assign plane_last = plane_index_reg == PL_W'(PLANES - 1);

    // Frame RAM addressing
    assign write_in_range = (int'(column) < COLUMNS) && (int'(row_number) < ROWS);
    assign pix_write = accept && (lmrsd_pkg::cmd_t'(command) == lmrsd_pkg::CMD_WRITE)
                       && write_in_range;
    assign pix_addr  = ADDR_W'(int'(row_number) * COLUMNS + int'(column));
    assign rd_addr   = ADDR_W'(int'(scan_row_reg) * COLUMNS + int'(shift_position_reg));
    assign rd_en     = is_tick && ((scan_phase_reg == lmrsd_pkg::PH_EVEN) ||
                                   (scan_phase_reg == lmrsd_pkg::PH_ODD));
    assign wr_addr   = clearing_reg ? clear_addr_reg : pix_addr;
    assign wr_data   = clearing_reg ? '0 : pixel_value;
    // draw buffer is a when display_select is 0
    assign wr_en_a   = clearing_reg || (pix_write && !display_select_reg);
    assign wr_en_b   = clearing_reg || (pix_write && display_select_reg);

    lmrsd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_a)
    );

    lmrsd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_b)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg        <= 1'b0;
            binary_on_ticks_reg  <= lmrsd_pkg::RST_BINARY_ON_TICKS;
            binary_threshold_reg <= lmrsd_pkg::RST_BINARY_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (lmrsd_pkg::reg_idx_t'(cfg_index))
                lmrsd_pkg::REG_SCAN_MODE:        scan_mode_reg        <= cfg_data[0];
                lmrsd_pkg::REG_BINARY_ON_TICKS:  binary_on_ticks_reg  <= cfg_data[ON_W-1:0];
                lmrsd_pkg::REG_BINARY_THRESHOLD: binary_threshold_reg <= cfg_data[PIX_W-1:0];
                default:                         ;
            endcase
        end
    end

    // Clearing pass over both buffers
    always_comb
    begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clearing_reg)
        begin
            if (clear_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        display_select_next = display_select_reg;
        scan_row_next       = scan_row_reg;
        plane_index_next    = plane_index_reg;
        shift_position_next = shift_position_reg;
        scan_phase_next     = scan_phase_reg;
        on_counter_next     = on_counter_reg;
        if (accept)
        begin
            case (lmrsd_pkg::cmd_t'(command))
                lmrsd_pkg::CMD_SWAP:
                begin
                    display_select_next = !display_select_reg;
                end
                lmrsd_pkg::CMD_TICK:
                begin
                    case (scan_phase_reg)
                        lmrsd_pkg::PH_EVEN, lmrsd_pkg::PH_ODD:
                        begin
                            if (int'(pos_sum) >= COLUMNS)
                            begin
                                if (scan_phase_reg == lmrsd_pkg::PH_EVEN)
                                begin
                                    shift_position_next = POS_W'(1);
                                    scan_phase_next     = lmrsd_pkg::PH_ODD;
                                end
                                else
                                begin
                                    shift_position_next = '0;
                                    scan_phase_next     = lmrsd_pkg::PH_LATCH;
                                end
                            end
                            else
                            begin
                                shift_position_next = pos_sum[POS_W-1:0];
                            end
                        end
                        lmrsd_pkg::PH_LATCH:
                        begin
                            on_counter_next = '0;
                            scan_phase_next = lmrsd_pkg::PH_ON;
                        end
                        lmrsd_pkg::PH_ON:
                        begin
                            if (on_end)
                            begin
                                on_counter_next     = '0;
                                shift_position_next = '0;
                                scan_phase_next     = lmrsd_pkg::PH_EVEN;
                                if (row_last)
                                begin
                                    scan_row_next = '0;
                                    if (scan_mode_reg && !plane_last)
                                    begin
                                        plane_index_next = plane_index_reg + PL_W'(1);
                                    end
                                    else
                                    begin
                                        plane_index_next = '0;
                                    end
                                end
                                else
                                begin
                                    scan_row_next = scan_row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                on_counter_next = cnt_sum[ON_W-1:0];
                            end
                        end
                        default:
                        begin
                            scan_phase_next = lmrsd_pkg::PH_EVEN;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pin levels of the accepted step
    always_comb
    begin
        step_comb          = '0;
        step_comb.en       = 1'b1;
        step_comb.ridx     = row_ext[RI_W-1:0];
        step_comb.sel      = display_select_reg;
        step_comb.thr      = scan_mode_reg ? PLANE_THR[plane3] : binary_threshold_reg;
        if (is_tick)
        begin
            case (scan_phase_reg)
                lmrsd_pkg::PH_EVEN:
                begin
                    step_comb.shifting = 1'b1;
                    step_comb.ce       = 1'b1;
                end
                lmrsd_pkg::PH_ODD:
                begin
                    step_comb.shifting = 1'b1;
                    step_comb.co       = 1'b1;
                end
                lmrsd_pkg::PH_LATCH:
                begin
                    step_comb.la = 1'b1;
                end
                lmrsd_pkg::PH_ON:
                begin
                    step_comb.la = 1'b1;
                    step_comb.en = 1'b0;
                    step_comb.rd = 1'b1;
                    step_comb.fd = on_end && row_last && (!scan_mode_reg || plane_last);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_select_reg <= 1'b0;
            scan_row_reg       <= '0;
            plane_index_reg    <= '0;
            shift_position_reg <= '0;
            scan_phase_reg     <= lmrsd_pkg::PH_EVEN;
            on_counter_reg     <= '0;
            clearing_reg       <= 1'b1;
            clear_addr_reg     <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            display_select_reg <= display_select_next;
            scan_row_reg       <= scan_row_next;
            plane_index_reg    <= plane_index_next;
            shift_position_reg <= shift_position_next;
            scan_phase_reg     <= scan_phase_next;
            on_counter_reg     <= on_counter_next;
            clearing_reg       <= clearing_next;
            clear_addr_reg     <= clear_addr_next;
            s1_valid_reg       <= s1_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Shift data from the display buffer read
    assign shown_pix = s1_reg.sel ? rd_data_a : rd_data_b;

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= step_comb;
        end
        if (advance)
        begin
            shift_data_reg <= s1_reg.shifting && (shown_pix > s1_reg.thr);
            clock_even_reg <= s1_reg.ce;
            clock_odd_reg  <= s1_reg.co;
            latch_reg      <= s1_reg.la;
            enable_n_reg   <= s1_reg.en;
            row_drive_reg  <= s1_reg.rd;
            row_index_reg  <= s1_reg.ridx;
            frame_done_reg <= s1_reg.fd;
        end
    end

    assign out_valid  = out_valid_reg;
    assign shift_data = shift_data_reg;
    assign clock_even = clock_even_reg;
    assign clock_odd  = clock_odd_reg;
    assign latch      = latch_reg;
    assign enable_n   = enable_n_reg;
    assign row_drive  = row_drive_reg;
    assign row_index  = row_index_reg;
    assign frame_done = frame_done_reg;

endmodule

// ===== hw/rtl/lmrsd_ram.sv =====
// Generic simple dual-port RAM with registered read and read enable.
module lmrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 630
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lmrsd_checker.sv =====
// Checker: port-level properties of the LED matrix scan driver, with its bind.
`include "led_matrix_row_scan_driver_defines.svh"

module lmrsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       clock_even,
    input logic       clock_odd,
    input logic       latch,
    input logic       enable_n,
    input logic       row_drive,
    input logic       frame_done
);

    // a stalled result stays offered
    `LMRSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // only one shift clock per step
    `LMRSD_ASSERT_IMPLY(a_one_clock, clk, rst_n, out_valid && clock_even, !clock_odd)

    // no latch or row drive while shifting
    `LMRSD_ASSERT_IMPLY(a_shift_quiet, clk, rst_n, out_valid && (clock_even || clock_odd),
        !latch && enable_n && !row_drive)

    // row drive comes with drivers enabled and latch held
    `LMRSD_ASSERT_IMPLY(a_row_on, clk, rst_n, out_valid && row_drive, !enable_n && latch)

    // frame end only on an on-time step
    `LMRSD_ASSERT_IMPLY(a_frame_on, clk, rst_n, out_valid && frame_done, row_drive)

endmodule

bind led_matrix_row_scan_driver lmrsd_checker u_lmrsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .clock_even (clock_even),
    .clock_odd  (clock_odd),
    .latch      (latch),
    .enable_n   (enable_n),
    .row_drive  (row_drive),
    .frame_done (frame_done)
);

// ===== bench/led_matrix_row_scan_driver_test.sv =====
// Self-checking bench for the LED matrix row scan driver: directed table, then random scan traffic.
module led_matrix_row_scan_driver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lmrsd_pkg::*;

    localparam int COLS         = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int PLANES       = DEF_PLANES;
    localparam int MAX_WAIT     = 12;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DIRECTED_N   = 20;

    // Command code the block has no meaning for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Row on-time per bit plane of the PWM scan
    localparam int PLANE_LIT [8] = '{1, 30, 60, 90, 120, 160, 250, 400};

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] col;
        logic [2:0] row;
        logic [7:0] pix;
    } req_t;

    typedef struct packed {
        logic       shift_data;
        logic       clock_even;
        logic       clock_odd;
        logic       latch;
        logic       enable_n;
        logic       row_drive;
        logic [2:0] row_index;
        logic       frame_done;
    } pins_t;

    typedef struct {
        req_t  req;
        bit    typed;
        pins_t pins;
    } step_row_t;

    localparam pins_t IDLE_R0 = '{shift_data: 1'b0, clock_even: 1'b0, clock_odd: 1'b0,
                                  latch: 1'b0, enable_n: 1'b1, row_drive: 1'b0,
                                  row_index: 3'd0, frame_done: 1'b0};
    localparam pins_t DARK_EVEN_R0 = '{shift_data: 1'b0, clock_even: 1'b1, clock_odd: 1'b0,
                                       latch: 1'b0, enable_n: 1'b1, row_drive: 1'b0,
                                       row_index: 3'd0, frame_done: 1'b0};

    // Directed requests; typed rows carry their pin levels, the rest use the predictor
    step_row_t directed_steps [DIRECTED_N] = '{
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b1, DARK_EVEN_R0}, // cleared store after reset
        '{'{CMD_WRITE,  7'd0,   3'd0, 8'd255}, 1'b1, IDLE_R0},
        '{'{CMD_WRITE,  7'd89,  3'd6, 8'd255}, 1'b1, IDLE_R0},
        '{'{CMD_WRITE,  7'd2,   3'd0, 8'd200}, 1'b1, IDLE_R0},
        '{'{CMD_WRITE,  7'd127, 3'd0, 8'd77},  1'b1, IDLE_R0},      // column off the panel
        '{'{CMD_WRITE,  7'd3,   3'd7, 8'd77},  1'b1, IDLE_R0},      // row off the panel
        '{'{CMD_UNUSED, 7'd127, 3'd7, 8'd255}, 1'b1, IDLE_R0},
        '{'{CMD_SWAP,   7'd0,   3'd0, 8'd0},   1'b1, IDLE_R0},
        '{'{CMD_TICK,   7'd127, 3'd7, 8'd255}, 1'b0, IDLE_R0},      // swap mid-row
        '{'{CMD_WRITE,  7'd4,   3'd0, 8'd1},   1'b1, IDLE_R0},
        '{'{CMD_WRITE,  7'd6,   3'd0, 8'd1},   1'b1, IDLE_R0},
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b0, IDLE_R0},
        '{'{CMD_SWAP,   7'd5,   3'd2, 8'd9},   1'b1, IDLE_R0},
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b0, IDLE_R0},
        '{'{CMD_WRITE,  7'd8,   3'd0, 8'd255}, 1'b1, IDLE_R0},
        '{'{CMD_SWAP,   7'd0,   3'd0, 8'd0},   1'b1, IDLE_R0},
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b0, IDLE_R0},
        '{'{CMD_WRITE,  7'd10,  3'd0, 8'd0},   1'b1, IDLE_R0},
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b0, IDLE_R0},
        '{'{CMD_TICK,   7'd0,   3'd0, 8'd0},   1'b0, IDLE_R0}
    };

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_DAT_W-1:0] cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           command     = '0;
    logic [6:0]           column      = '0;
    logic [2:0]           row_number  = '0;
    logic [PIXEL_W-1:0]   pixel_value = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 shift_data;
    logic                 clock_even;
    logic                 clock_odd;
    logic                 latch;
    logic                 enable_n;
    logic                 row_drive;
    logic [ROWIDX_W-1:0]  row_index;
    logic                 frame_done;

    // Predicted scanner state and register copies
    logic [7:0]  buffer_a [ROWS*COLS];
    logic [7:0]  buffer_b [ROWS*COLS];
    bit          show_a;
    int          cur_row;
    int          cur_plane;
    int          shift_col;
    int          lit_count;
    phase_t      row_phase;
    bit          pwm_scan;
    logic [15:0] bin_on_time;
    logic [7:0]  bin_threshold;

    pins_t pin_levels_due [$];
    int    mismatch_count = 0;
    int    stall_left     = 0;
    bit    quiet_in       = 1'b0;
    bit    quiet_out      = 1'b0;

    led_matrix_row_scan_driver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .column      (column),
        .row_number  (row_number),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .shift_data  (shift_data),
        .clock_even  (clock_even),
        .clock_odd   (clock_odd),
        .latch       (latch),
        .enable_n    (enable_n),
        .row_drive   (row_drive),
        .row_index   (row_index),
        .frame_done  (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predictor state as it stands after reset
    initial
    begin
        foreach (buffer_a[i])
        begin
            buffer_a[i] = '0;
            buffer_b[i] = '0;
        end
        show_a        = 1'b0;
        cur_row       = 0;
        cur_plane     = 0;
        shift_col     = 0;
        lit_count     = 0;
        row_phase     = PH_EVEN;
        pwm_scan      = 1'b0;
        bin_on_time   = RST_BINARY_ON_TICKS;
        bin_threshold = RST_BINARY_THRESHOLD;
    end

    // Advance the predicted scanner by one request and give the pin levels it shows
    function automatic pins_t step_scanner(input req_t r);
        pins_t p;
        int    idx;
        int    shown;
        int    thr;
        int    on_limit;
        p           = '0;
        p.enable_n  = 1'b1;
        p.row_index = 3'(cur_row);
        case (r.cmd)
            CMD_WRITE:
            begin
                if (int'(r.col) < COLS && int'(r.row) < ROWS)
                begin
                    idx = int'(r.row) * COLS + int'(r.col);
                    if (show_a)
                        buffer_b[idx] = r.pix;
                    else
                        buffer_a[idx] = r.pix;
                end
            end
            CMD_SWAP:
                show_a = !show_a;
            CMD_TICK:
            begin
                case (row_phase)
                    PH_EVEN, PH_ODD:
                    begin
                        idx   = cur_row * COLS + shift_col;
                        shown = show_a ? buffer_a[idx] : buffer_b[idx];
                        thr   = pwm_scan ? (cur_plane % PLANES) * 256 / PLANES
                                         : int'(bin_threshold);
                        p.shift_data = shown > thr;
                        if (row_phase == PH_EVEN)
                            p.clock_even = 1'b1;
                        else
                            p.clock_odd = 1'b1;
                        shift_col += 2;
                        if (shift_col >= COLS)
                        begin
                            if (row_phase == PH_EVEN)
                            begin
                                shift_col = 1;
                                row_phase = PH_ODD;
                            end
                            else
                            begin
                                shift_col = 0;
                                row_phase = PH_LATCH;
                            end
                        end
                    end
                    PH_LATCH:
                    begin
                        p.latch   = 1'b1;
                        lit_count = 0;
                        row_phase = PH_ON;
                    end
                    default:
                    begin
                        p.latch     = 1'b1;
                        p.enable_n  = 1'b0;
                        p.row_drive = 1'b1;
                        lit_count++;
                        // registers are live: the on-time is read at every tick
                        on_limit = pwm_scan ? PLANE_LIT[cur_plane % 8]
                                            : (bin_on_time == 0 ? 1 : int'(bin_on_time));
                        if (lit_count >= on_limit)
                        begin
                            lit_count = 0;
                            shift_col = 0;
                            row_phase = PH_EVEN;
                            cur_row++;
                            if (cur_row >= ROWS)
                            begin
                                cur_row = 0;
                                if (pwm_scan)
                                begin
                                    cur_plane++;
                                    if (cur_plane >= PLANES)
                                    begin
                                        cur_plane    = 0;
                                        p.frame_done = 1'b1;
                                    end
                                end
                                else
                                begin
                                    // binary scan always restarts on plane zero
                                    cur_plane    = 0;
                                    p.frame_done = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
            default:
                ;
        endcase
        return p;
    endfunction

    // Random request: mostly ticks, writes with shaped content, a few swaps and stray codes
    function automatic req_t random_request(input int tick_pct);
        req_t r;
        int   pick;
        r.cmd = 2'($urandom);
        r.col = 7'($urandom);
        r.row = 3'($urandom);
        r.pix = 8'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < tick_pct)
            r.cmd = CMD_TICK;
        else if (pick < 97)
        begin
            r.cmd = CMD_WRITE;
            if ($urandom_range(0, 15) != 0)
            begin
                r.col = 7'($urandom_range(0, COLS - 1));
                r.row = 3'($urandom_range(0, ROWS - 1));
            end
            case ($urandom_range(0, 3))
                0: r.pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                1: r.pix = 8'($urandom_range(0, 7) * 32 + $urandom_range(0, 1));
                default: ;
            endcase
        end
        else if (pick < 99)
            r.cmd = CMD_SWAP;
        else
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    task automatic wait_drain();
        while (pin_levels_due.size() != 0)
            @(posedge clk);
    endtask

    // Offer one request, wait for it to be taken, then record its expected pin levels
    task automatic send_request(input req_t r, input bit typed, input pins_t typed_pins);
        int    gap;
        bit    pause;
        pins_t predicted;
        gap   = quiet_in ? 0 : $urandom_range(0, MAX_WAIT);
        pause = $urandom_range(0, 299) == 0;
        // a pause always drops valid, even when no gap was drawn
        if (pause && gap == 0)
            gap = 1;
        if ($urandom_range(0, 39) == 0)
            quiet_in = !quiet_in;
        if (gap > 0 || pause)
            in_valid <= 1'b0;
        if (pause)
            wait_drain();
        repeat (gap) @(posedge clk);
        in_valid    <= 1'b1;
        command     <= r.cmd;
        column      <= r.col;
        row_number  <= r.row;
        pixel_value <= r.pix;
        do
            @(posedge clk);
        while (in_stall);
        predicted = step_scanner(r);
        pin_levels_due.push_back(typed ? typed_pins : predicted);
    endtask

    // Register write, only once the block has gone quiet
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SCAN_MODE:        pwm_scan      = value[0];
            REG_BINARY_ON_TICKS:  bin_on_time   = value;
            REG_BINARY_THRESHOLD: bin_threshold = value[7:0];
            default: ;
        endcase
    endtask

    task automatic run_random(input int count, input int tick_pct);
        repeat (count) send_request(random_request(tick_pct), 1'b0, IDLE_R0);
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    task automatic check_pins();
        pins_t got;
        pins_t want;
        got = {shift_data, clock_even, clock_odd, latch, enable_n, row_drive, row_index,
               frame_done};
        if (pin_levels_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result with no request pending: %b", got);
        end
        else
        begin
            want = pin_levels_due.pop_front();
            compare_field("shift_data", want.shift_data, got.shift_data);
            compare_field("clock_even", want.clock_even, got.clock_even);
            compare_field("clock_odd",  want.clock_odd,  got.clock_odd);
            compare_field("latch",      want.latch,      got.latch);
            compare_field("enable_n",   want.enable_n,   got.enable_n);
            compare_field("row_drive",  want.row_drive,  got.row_drive);
            compare_field("row_index",  want.row_index,  got.row_index);
            compare_field("frame_done", want.frame_done, got.frame_done);
        end
    endtask

    // Result side: check each taken result, then stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_pins();
            stall_left = quiet_out ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0)
                quiet_out = !quiet_out;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("led_matrix_row_scan_driver_test NOT OK");
        $finish;
    end

    // Request side
    initial
    begin
        req_t tick_req;
        tick_req = '{cmd: CMD_TICK, col: 7'd0, row: 3'd0, pix: 8'd0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, reset register values
        for (int k = 0; k < DIRECTED_N; k++)
            send_request(directed_steps[k].req, directed_steps[k].typed,
                         directed_steps[k].pins);

        // binary scan, zero on-time behaves as one tick, long enough for a whole frame
        write_reg(REG_BINARY_ON_TICKS, 16'd0);
        write_reg(REG_BINARY_THRESHOLD, 16'd100);
        run_random(740, 92);

        // longest on-time, cut short once the row is lit
        write_reg(REG_BINARY_ON_TICKS, 16'hFFFF);
        write_reg(REG_BINARY_THRESHOLD, 16'd255);
        while (!(row_phase == PH_ON && lit_count >= 20))
            send_request(tick_req, 1'b0, IDLE_R0);
        write_reg(REG_BINARY_ON_TICKS, 16'd3);
        run_random(60, 70);

        // PWM scan into the middle of a frame
        write_reg(REG_BINARY_ON_TICKS, 16'd1);
        write_reg(REG_SCAN_MODE, 16'd1);
        run_random(150, 85);

        // back to binary mid-frame with a fresh threshold
        write_reg(REG_SCAN_MODE, 16'd0);
        write_reg(REG_BINARY_THRESHOLD, 16'($urandom_range(0, 255)));
        run_random(100, 85);

        // PWM scan once more to close
        write_reg(REG_SCAN_MODE, 16'd1);
        run_random(90, 92);

        in_valid <= 1'b0;
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("led_matrix_row_scan_driver_test OK");
        else
            $display("led_matrix_row_scan_driver_test NOT OK");
        $finish;
    end

endmodule
